>>> hdl/pfr_pkg.sv
// shared constants for the pause fade ramp controller
package pfr_pkg;

  // gain fraction bits (unsigned q0.16, unity needs one more bit)
  localparam int GAIN_BITS = 16;
  // step counter width for the bit-serial units, holds GAIN_BITS
  localparam int STEP_CNT_W = $clog2(GAIN_BITS + 1);

  // item modes
  localparam logic [3:0] MODE_FRAME     = 4'd0;
  localparam logic [3:0] MODE_INIT      = 4'd1;
  localparam logic [3:0] MODE_QUEUED    = 4'd2;
  localparam logic [3:0] MODE_EOS       = 4'd3;
  localparam logic [3:0] MODE_PAUSE     = 4'd4;
  localparam logic [3:0] MODE_UNPAUSE   = 4'd5;
  localparam logic [3:0] MODE_UNDERFLOW = 4'd6;
  localparam logic [3:0] MODE_DELETE    = 4'd7;
  localparam logic [3:0] MODE_ERROR     = 4'd8;

  // stream states
  localparam logic [2:0] ST_UNINIT  = 3'd0;
  localparam logic [2:0] ST_NORMAL  = 3'd1;
  localparam logic [2:0] ST_FADING  = 3'd2;
  localparam logic [2:0] ST_PAUSED  = 3'd3;
  localparam logic [2:0] ST_EOS     = 3'd4;
  localparam logic [2:0] ST_FINAL   = 3'd5;
  localparam logic [2:0] ST_DELETED = 3'd6;
  localparam logic [2:0] ST_ERROR   = 3'd7;

  // register indexes on the config port
  localparam logic REG_FADE_FRAMES  = 1'b0;
  localparam logic REG_FADE_IN_SPAN = 1'b1;

endpackage

>>> hdl/pfr_div.sv
// bit-serial restoring divider for a q0.16 gain ratio num/den, num below den
module pfr_div #(
  parameter int W = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [W-1:0]                num,
  input  logic [W-1:0]                den,
  output logic                        done,
  output logic [pfr_pkg::GAIN_BITS-1:0] quo
);

  logic [W-1:0]                    rem;
  logic [W-1:0]                    den_r;
  logic [pfr_pkg::STEP_CNT_W-1:0]  cnt;
  logic [W:0]                      r2;
  logic [W:0]                      diff;
  logic                            take;

  // one quotient bit per cycle
  assign r2   = {rem, 1'b0};
  assign diff = r2 - {1'b0, den_r};
  assign take = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= pfr_pkg::STEP_CNT_W'(pfr_pkg::GAIN_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == pfr_pkg::STEP_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quo   <= '0;
    end else if (cnt != '0) begin
      rem <= take ? diff[W-1:0] : r2[W-1:0];
      quo <= {quo[pfr_pkg::GAIN_BITS-2:0], take};
    end
  end

endmodule

>>> hdl/pfr_mul.sv
// bit-serial stereo gain multiplier with round half up, one gain bit per cycle
module pfr_mul #(
  parameter int SB = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SB-1:0]          left,
  input  logic signed [SB-1:0]          right,
  input  logic [pfr_pkg::GAIN_BITS-1:0] gain,
  output logic                          done,
  output logic signed [SB-1:0]          left_res,
  output logic signed [SB-1:0]          right_res
);

  logic signed [SB-1:0]            l_r;
  logic signed [SB-1:0]            r_r;
  logic [pfr_pkg::GAIN_BITS-1:0]   g_sh;
  logic signed [SB:0]              acc_l;
  logic signed [SB:0]              acc_r;
  logic [pfr_pkg::GAIN_BITS-1:0]   low_l;
  logic [pfr_pkg::GAIN_BITS-1:0]   low_r;
  logic signed [SB:0]              sum_l;
  logic signed [SB:0]              sum_r;
  logic [pfr_pkg::STEP_CNT_W-1:0]  cnt;

  // lsb-first shift-add, the low product bits shift out into low_*
  assign sum_l = acc_l + (g_sh[0] ? {l_r[SB-1], l_r} : '0);
  assign sum_r = acc_r + (g_sh[0] ? {r_r[SB-1], r_r} : '0);

  // upper product plus the rounding bit, gain at most unity so it fits
  assign left_res  = SB'(acc_l + {{SB{1'b0}}, low_l[pfr_pkg::GAIN_BITS-1]});
  assign right_res = SB'(acc_r + {{SB{1'b0}}, low_r[pfr_pkg::GAIN_BITS-1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= pfr_pkg::STEP_CNT_W'(pfr_pkg::GAIN_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == pfr_pkg::STEP_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      l_r   <= left;
      r_r   <= right;
      g_sh  <= gain;
      acc_l <= '0;
      acc_r <= '0;
      low_l <= '0;
      low_r <= '0;
    end else if (cnt != '0) begin
      acc_l <= sum_l >>> 1;
      acc_r <= sum_r >>> 1;
      low_l <= {sum_l[0], low_l[pfr_pkg::GAIN_BITS-1:1]};
      low_r <= {sum_r[0], low_r[pfr_pkg::GAIN_BITS-1:1]};
      g_sh  <= {1'b0, g_sh[pfr_pkg::GAIN_BITS-1:1]};
    end
  end

endmodule

>>> hdl/pause_fade_ramp_controller.sv
// top level of the stereo pause / fade gain ramp controller
//
// input channel (in_valid / in_stall) carries one word per item: a mode code,
// two signed samples and a precomputed drain length for delete requests.
// every item gives exactly one output word (out_valid / out_stall): two faded
// samples and the stream state after the item. control events give zero samples.
// the apb port holds fade_frames (0x0) and fade_in_span (0x4); write only while
// the block is idle.
// one item is worked on at a time. control events, silent and pass-through
// frames go from accept through the done state into the output register.
// frames on a fade ramp first pass the bit-serial divider for the
// remaining/total ratio (remaining/span on a fade-in), then the bit-serial
// multiplier that scales both channels. these two serial units set the rate.
// the output register lets the next item be accepted while a finished word
// still waits; a stalled receiver holds the word and, once the next result is
// ready, the block stops accepting until the word is taken.
// synchronous reset restores fade_frames 768, fade_in_span 720, uninit state,
// zero counters and an empty output.
module pause_fade_ramp_controller #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    mode,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic [15:0]                   drain_frames,
  // output words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic [2:0]                    stream_state
);

  // common width for count and divisor compares
  localparam int DEN_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // how the frame result is formed
  localparam logic [1:0] K_ZERO = 2'd0;
  localparam logic [1:0] K_PASS = 2'd1;
  localparam logic [1:0] K_DIV  = 2'd2;

  // saturate a 16 bit length to the counter width
  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [15:0] v);
    logic [DEN_W-1:0] w;
    w = DEN_W'(v);
    return (w > DEN_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(w);
  endfunction

  logic [15:0]                   fade_frames;
  logic [15:0]                   fade_in_span;
  logic [2:0]                    play_state;
  logic [COUNT_BITS-1:0]         fade_remaining;
  logic [COUNT_BITS-1:0]         fade_total;
  logic [1:0]                    seq;
  logic [1:0]                    kind;
  logic                          fade_in;
  logic [2:0]                    state_res;
  logic signed [SAMPLE_BITS-1:0] left_s;
  logic signed [SAMPLE_BITS-1:0] right_s;

  logic [2:0]                    state_next;
  logic [COUNT_BITS-1:0]         rem_next;
  logic [COUNT_BITS-1:0]         tot_next;
  logic [1:0]                    kind_next;
  logic                          fade_in_next;
  logic [DEN_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;

  logic                          accept;
  logic                          cfg_wr;
  logic                          div_start;
  logic                          div_done;
  logic [pfr_pkg::GAIN_BITS-1:0] quo;
  logic [pfr_pkg::GAIN_BITS-1:0] gain;
  logic                          mul_done;
  logic signed [SAMPLE_BITS-1:0] left_mul;
  logic signed [SAMPLE_BITS-1:0] right_mul;
  logic                          out_load;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_stall = (seq != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign out_load = (seq == S_DONE) & (~out_valid | ~out_stall);

  // register read back
  always_comb begin
    unique case (paddr[2])
      pfr_pkg::REG_FADE_FRAMES:  prdata = {16'd0, fade_frames};
      pfr_pkg::REG_FADE_IN_SPAN: prdata = {16'd0, fade_in_span};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_frames  <= 16'd768;
      fade_in_span <= 16'd720;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pfr_pkg::REG_FADE_FRAMES:  fade_frames  <= pwdata[15:0];
        pfr_pkg::REG_FADE_IN_SPAN: fade_in_span <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // stream state update, worked out in full at accept; only the gain of a
  // ramped frame is left to the serial units
  always_comb begin
    logic                  deleting;
    logic [COUNT_BITS-1:0] nff;
    logic [COUNT_BITS-1:0] drain;
    logic [COUNT_BITS-1:0] rem_tmp;
    logic [DEN_W-1:0]      rem_w;
    logic [DEN_W-1:0]      tot_w;
    logic [DEN_W-1:0]      span_w;

    deleting = (play_state == pfr_pkg::ST_FINAL) || (play_state == pfr_pkg::ST_DELETED);
    nff      = sat_cnt(fade_frames);
    drain    = sat_cnt(drain_frames);
    rem_w    = DEN_W'(fade_remaining);
    tot_w    = DEN_W'(fade_total);
    span_w   = DEN_W'(fade_in_span);
    rem_tmp  = fade_remaining;

    state_next   = play_state;
    rem_next     = fade_remaining;
    tot_next     = fade_total;
    kind_next    = K_ZERO;
    fade_in_next = 1'b0;
    div_num      = rem_w;
    div_den      = tot_w;

    unique case (mode)
      pfr_pkg::MODE_FRAME: begin
        if (play_state == pfr_pkg::ST_PAUSED || play_state == pfr_pkg::ST_DELETED) begin
          kind_next = K_ZERO;
        end else if (play_state == pfr_pkg::ST_FADING || play_state == pfr_pkg::ST_FINAL) begin
          if (fade_remaining != '0) begin
            // fade out, unity gain when the ratio saturates
            kind_next = (fade_total == '0 || rem_w >= tot_w) ? K_PASS : K_DIV;
            rem_tmp   = fade_remaining - 1'b1;
          end
          rem_next = rem_tmp;
          if (rem_tmp == '0) begin
            state_next = (play_state == pfr_pkg::ST_FINAL) ? pfr_pkg::ST_DELETED
                                                           : pfr_pkg::ST_PAUSED;
          end
        end else if (fade_remaining != '0) begin
          // fade in, zero gain while remaining is at or above the span
          kind_next    = (fade_in_span == '0 || rem_w >= span_w) ? K_ZERO : K_DIV;
          fade_in_next = 1'b1;
          div_den      = span_w;
          rem_next     = fade_remaining - 1'b1;
        end else begin
          kind_next = K_PASS;
        end
      end
      pfr_pkg::MODE_INIT: begin
        if (!deleting) begin
          tot_next = nff;
          rem_next = nff;
        end
      end
      pfr_pkg::MODE_QUEUED: begin
        if (!deleting && play_state == pfr_pkg::ST_UNINIT) begin
          state_next = pfr_pkg::ST_NORMAL;
        end
      end
      pfr_pkg::MODE_EOS: begin
        if (!deleting) begin
          state_next = pfr_pkg::ST_EOS;
        end
      end
      pfr_pkg::MODE_PAUSE: begin
        if (play_state == pfr_pkg::ST_UNINIT) begin
          state_next = pfr_pkg::ST_PAUSED;
        end else if (play_state == pfr_pkg::ST_NORMAL) begin
          rem_tmp    = (nff > fade_remaining) ? nff - fade_remaining : '0;
          rem_next   = rem_tmp;
          state_next = (rem_tmp != '0) ? pfr_pkg::ST_FADING : pfr_pkg::ST_PAUSED;
        end
      end
      pfr_pkg::MODE_UNPAUSE: begin
        if (play_state == pfr_pkg::ST_FADING) begin
          rem_next   = (nff > fade_remaining) ? nff - fade_remaining : '0;
          state_next = pfr_pkg::ST_NORMAL;
        end else if (play_state == pfr_pkg::ST_PAUSED) begin
          rem_next   = nff;
          state_next = pfr_pkg::ST_NORMAL;
        end
      end
      pfr_pkg::MODE_UNDERFLOW: begin
        if (play_state == pfr_pkg::ST_NORMAL) begin
          rem_next = nff;
        end
      end
      pfr_pkg::MODE_DELETE: begin
        if (!deleting) begin
          if (play_state != pfr_pkg::ST_NORMAL && play_state != pfr_pkg::ST_FADING &&
              play_state != pfr_pkg::ST_EOS) begin
            state_next = pfr_pkg::ST_DELETED;
          end else begin
            if (play_state == pfr_pkg::ST_EOS) begin
              rem_tmp  = drain;
              tot_next = drain;
            end else if (play_state == pfr_pkg::ST_NORMAL) begin
              rem_tmp  = (drain < nff) ? drain : nff;
              tot_next = rem_tmp;
            end
            rem_next   = rem_tmp;
            state_next = (rem_tmp == '0) ? pfr_pkg::ST_DELETED : pfr_pkg::ST_FINAL;
          end
        end
      end
      pfr_pkg::MODE_ERROR: begin
        state_next = (play_state == pfr_pkg::ST_FINAL) ? pfr_pkg::ST_DELETED
                                                       : pfr_pkg::ST_ERROR;
      end
      default: ;
    endcase
  end

  assign div_start = accept & (kind_next == K_DIV);

  // fade in uses 1 - ratio; the ratio is at least one lsb here since
  // remaining is nonzero and below the span
  assign gain = fade_in ? (~quo + 1'b1) : quo;

  pfr_div #(
    .W(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  pfr_mul #(
    .SB(SAMPLE_BITS)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (div_done),
    .left      (left_s),
    .right     (right_s),
    .gain      (gain),
    .done      (mul_done),
    .left_res  (left_mul),
    .right_res (right_mul)
  );

  // stream state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      play_state     <= pfr_pkg::ST_UNINIT;
      fade_remaining <= '0;
      fade_total     <= '0;
      seq            <= S_IDLE;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        play_state     <= state_next;
        fade_remaining <= rem_next;
        fade_total     <= tot_next;
      end
      unique case (seq)
        S_IDLE: if (accept) seq <= (kind_next == K_DIV) ? S_DIV : S_DONE;
        S_DIV:  if (div_done) seq <= S_MUL;
        S_MUL:  if (mul_done) seq <= S_DONE;
        S_DONE: if (out_load) seq <= S_IDLE;
        default: seq <= S_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per item payload held for the job
  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= kind_next;
      fade_in   <= fade_in_next;
      state_res <= state_next;
      left_s    <= left_in;
      right_s   <= right_in;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      stream_state <= state_res;
      case (kind)
        K_PASS: begin
          left_out  <= left_s;
          right_out <= right_s;
        end
        K_DIV: begin
          left_out  <= left_mul;
          right_out <= right_mul;
        end
        default: begin
          left_out  <= '0;
          right_out <= '0;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the stereo pause / fade gain ramp controller
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = 24;
  // cycles allowed for a ramped frame to clear the serial divider and multiplier
  localparam int SETTLE_CYCLES = 48;
  // bound on the whole run, set with a wide margin over the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;
  // keep a broken design from flooding the log
  localparam int MAX_PRINTED = 200;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;
  localparam logic [16:0] UNITY_GAIN = 17'd65536;

  // one input word: mode, both samples, drain length, and a flag that makes the
  // driver wait until every expected output word has come back
  typedef struct packed {
    logic [3:0]                 mode;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [15:0]                drain;
    logic                       hold;
  } in_word_t;

  // one output word as the block should give it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [2:0]                 state;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [3:0]                 mode         = pfr_pkg::MODE_FRAME;
  logic signed [SAMPLE_W-1:0] left_in      = '0;
  logic signed [SAMPLE_W-1:0] right_in     = '0;
  logic [15:0]                drain_frames = '0;

  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [2:0]                 stream_state;

  // words waiting to be sent, and output words the block still owes us
  in_word_t  pending_words[$];
  out_word_t expected_words[$];

  // shadow of the config registers, only changed while the block is idle
  logic [15:0] cfg_fade_frames = 16'd768;
  logic [15:0] cfg_fade_in_span = 16'd720;

  // shadow of the stream: state and the two fade counters
  logic [2:0]  stream_st = pfr_pkg::ST_UNINIT;
  logic [15:0] fade_left_cnt = '0;
  logic [15:0] fade_len = '0;

  // idling knobs set per phase; calm switches all idling off near the end
  int unsigned idle_pct = 0;
  bit          calm = 1'b0;
  int unsigned tx_burst = 0;
  int unsigned rx_burst = 0;

  int unsigned mismatches = 0;
  int unsigned leftovers = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned ramp_frames = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  states_seen = '0;

  pause_fade_ramp_controller #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS (16)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .left_in     (left_in),
    .right_in    (right_in),
    .drain_frames(drain_frames),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_out    (left_out),
    .right_out   (right_out),
    .stream_state(stream_state)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // gain arithmetic
  // ---------------------------------------------------------------------------

  // q0.16 ratio num/den, floored, capped at unity; a zero divisor means unity
  function automatic logic [16:0] gain_ratio(logic [15:0] num, logic [15:0] den);
    logic [31:0] quot;
    if (den == 16'd0) return UNITY_GAIN;
    quot = {num, 16'd0} / {16'd0, den};
    return (quot > 32'd65536) ? UNITY_GAIN : quot[16:0];
  endfunction

  // sample times gain with round half up; gain never exceeds unity so it fits
  function automatic logic signed [SAMPLE_W-1:0] apply_gain(
    logic signed [SAMPLE_W-1:0] s, logic [16:0] g);
    logic signed [42:0] prod;
    prod = 43'(s) * 43'($signed({1'b0, g})) + 43'sd32768;
    // arithmetic shift by 16 is a floor division for both signs
    return prod[39:16];
  endfunction

  // ---------------------------------------------------------------------------
  // stream predictor: advances the shadow state by one word and gives the
  // output word the block must produce for it
  // ---------------------------------------------------------------------------
  function automatic out_word_t fade_step(in_word_t w);
    out_word_t   o;
    logic        deleting;
    logic [16:0] g;
    o = '0;
    deleting = (stream_st == pfr_pkg::ST_FINAL) || (stream_st == pfr_pkg::ST_DELETED);
    case (w.mode)
      pfr_pkg::MODE_FRAME: begin
        if (stream_st == pfr_pkg::ST_PAUSED || stream_st == pfr_pkg::ST_DELETED) begin
          // silent
        end else if (stream_st == pfr_pkg::ST_FADING || stream_st == pfr_pkg::ST_FINAL) begin
          // fade out: gain remaining/total, then end as paused or deleted
          if (fade_left_cnt != 16'd0) begin
            g = gain_ratio(fade_left_cnt, fade_len);
            o.left  = apply_gain(w.left, g);
            o.right = apply_gain(w.right, g);
            fade_left_cnt = fade_left_cnt - 16'd1;
            ramp_frames++;
          end
          if (fade_left_cnt == 16'd0)
            stream_st = (stream_st == pfr_pkg::ST_FINAL) ? pfr_pkg::ST_DELETED
                                                          : pfr_pkg::ST_PAUSED;
        end else if (fade_left_cnt != 16'd0) begin
          // fade in: 1 - remaining/span, pinned at zero at or above the span
          g = UNITY_GAIN - gain_ratio(fade_left_cnt, cfg_fade_in_span);
          o.left  = apply_gain(w.left, g);
          o.right = apply_gain(w.right, g);
          fade_left_cnt = fade_left_cnt - 16'd1;
          ramp_frames++;
        end else begin
          o.left  = w.left;
          o.right = w.right;
        end
      end
      pfr_pkg::MODE_INIT: begin
        if (!deleting) begin
          fade_len      = cfg_fade_frames;
          fade_left_cnt = cfg_fade_frames;
        end
      end
      pfr_pkg::MODE_QUEUED: begin
        if (!deleting && stream_st == pfr_pkg::ST_UNINIT) stream_st = pfr_pkg::ST_NORMAL;
      end
      pfr_pkg::MODE_EOS: begin
        if (!deleting) stream_st = pfr_pkg::ST_EOS;
      end
      pfr_pkg::MODE_PAUSE: begin
        if (stream_st == pfr_pkg::ST_UNINIT) begin
          stream_st = pfr_pkg::ST_PAUSED;
        end else if (stream_st == pfr_pkg::ST_NORMAL) begin
          // turn the ramp around, saturating at zero
          fade_left_cnt = (cfg_fade_frames > fade_left_cnt) ?
                          cfg_fade_frames - fade_left_cnt : 16'd0;
          stream_st = (fade_left_cnt != 16'd0) ? pfr_pkg::ST_FADING : pfr_pkg::ST_PAUSED;
        end
      end
      pfr_pkg::MODE_UNPAUSE: begin
        if (stream_st == pfr_pkg::ST_FADING) begin
          fade_left_cnt = (cfg_fade_frames > fade_left_cnt) ?
                          cfg_fade_frames - fade_left_cnt : 16'd0;
          stream_st = pfr_pkg::ST_NORMAL;
        end else if (stream_st == pfr_pkg::ST_PAUSED) begin
          fade_left_cnt = cfg_fade_frames;
          stream_st = pfr_pkg::ST_NORMAL;
        end
      end
      pfr_pkg::MODE_UNDERFLOW: begin
        if (stream_st == pfr_pkg::ST_NORMAL) fade_left_cnt = cfg_fade_frames;
      end
      pfr_pkg::MODE_DELETE: begin
        if (!deleting) begin
          if (stream_st != pfr_pkg::ST_NORMAL && stream_st != pfr_pkg::ST_FADING &&
              stream_st != pfr_pkg::ST_EOS) begin
            stream_st = pfr_pkg::ST_DELETED;
          end else begin
            // fading keeps its counters; eos takes the drain, normal it capped to fade length
            if (stream_st == pfr_pkg::ST_EOS) begin
              fade_len      = w.drain;
              fade_left_cnt = w.drain;
            end else if (stream_st == pfr_pkg::ST_NORMAL) begin
              fade_len      = (w.drain < cfg_fade_frames) ? w.drain : cfg_fade_frames;
              fade_left_cnt = fade_len;
            end
            stream_st = (fade_left_cnt == 16'd0) ? pfr_pkg::ST_DELETED : pfr_pkg::ST_FINAL;
          end
        end
      end
      pfr_pkg::MODE_ERROR: begin
        stream_st = (stream_st == pfr_pkg::ST_FINAL) ? pfr_pkg::ST_DELETED
                                                      : pfr_pkg::ST_ERROR;
      end
      default: begin
        // unknown modes leave everything alone
      end
    endcase
    o.state = stream_st;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: holds the head of pending_words on the input channel until it is
  // taken, predicting its output word at the accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    logic taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        expected_words = {expected_words, fade_step(pending_words[0])};
        pending_words.delete(0);
        words_sent++;
      end
      if (in_valid && !taken) begin
        // stalled, payload stays put
      end else if (tx_burst != 0) begin
        tx_burst--;
        in_valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_words[0].hold && expected_words.size() != 0) begin
        // let the block run dry before this word goes out
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        // start an idle burst, its length drawn into tx_burst
        tx_burst = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else begin
        in_valid     <= 1'b1;
        mode         <= pending_words[0].mode;
        left_in      <= pending_words[0].left;
        right_in     <= pending_words[0].right;
        drain_frames <= pending_words[0].drain;
      end
    end
  end

  // mismatch report, prints a bounded number of lines but counts all
  task automatic note_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch on %s at output word %0d: got %0d, want %0d",
               what, words_checked, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: takes each output word and compares it with the oldest expected
  // word; also drives out_stall in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_monitor
    out_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        states_seen[stream_state] = 1'b1;
        if (expected_words.size() == 0) begin
          note_mismatch("unexpected word, stream_state", int'(stream_state), -1);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (left_out !== want.left)
            note_mismatch("left_out", int'(left_out), int'(want.left));
          if (right_out !== want.right)
            note_mismatch("right_out", int'(right_out), int'(want.right));
          if (stream_state !== want.state)
            note_mismatch("stream_state", int'(stream_state), int'(want.state));
        end
        words_checked++;
      end
      if (rx_burst != 0) begin
        rx_burst--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        rx_burst = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // apb write: setup cycle, then access cycle; the register takes the value at
  // the edge where psel, penable, pwrite and pready are all high
  task automatic apb_write(logic idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // called only with the block idle
  task automatic set_config(logic [15:0] frames, logic [15:0] span);
    apb_write(pfr_pkg::REG_FADE_FRAMES, frames);
    apb_write(pfr_pkg::REG_FADE_IN_SPAN, span);
    cfg_fade_frames  = frames;
    cfg_fade_in_span = span;
    settings_used++;
  endtask

  // wait until everything sent has come back, then let the block settle
  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full-range sample with the extremes mixed in often
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 11))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return -24'sd1;
      default: return raw[SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic push_word(logic [3:0] m, logic signed [SAMPLE_W-1:0] l,
                           logic signed [SAMPLE_W-1:0] r, logic [15:0] d, bit hold);
    in_word_t w;
    w.mode  = m;
    w.left  = l;
    w.right = r;
    w.drain = d;
    w.hold  = hold;
    pending_words = {pending_words, w};
  endtask

  // random traffic of control events each followed by a run of frames (at times
  // empty late on), one pick in five a lone noise word instead; early phases stay
  // in the normal/fading/paused region, late ones cycle through eos, delete, error
  task automatic push_traffic(int unsigned n, bit late);
    int unsigned count;
    int unsigned run;
    int unsigned pick;
    logic [3:0]  m;
    logic [15:0] d;
    count = 0;
    while (count < n) begin
      d = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 4) == 0) begin
        m = 4'($urandom_range(0, 15));
        if (!late && (m == pfr_pkg::MODE_EOS || m == pfr_pkg::MODE_DELETE ||
                      m == pfr_pkg::MODE_ERROR))
          m = pfr_pkg::MODE_FRAME;
        push_word(m, rand_sample(), rand_sample(), d, count == n / 2);
        count++;
      end else begin
        pick = late ? $urandom_range(0, 11) : $urandom_range(0, 9);
        if (late) begin
          case (pick)
            0, 1, 2: m = pfr_pkg::MODE_EOS;
            3, 4, 5: m = pfr_pkg::MODE_DELETE;
            6, 7:    m = pfr_pkg::MODE_ERROR;
            8:       m = pfr_pkg::MODE_INIT;
            9:       m = pfr_pkg::MODE_PAUSE;
            10:      m = pfr_pkg::MODE_UNPAUSE;
            default: m = ($urandom_range(0, 1) != 0) ? pfr_pkg::MODE_UNDERFLOW
                                                      : pfr_pkg::MODE_QUEUED;
          endcase
        end else begin
          case (pick)
            0:       m = pfr_pkg::MODE_INIT;
            1:       m = pfr_pkg::MODE_QUEUED;
            2, 3, 4: m = pfr_pkg::MODE_PAUSE;
            5, 6, 7: m = pfr_pkg::MODE_UNPAUSE;
            default: m = pfr_pkg::MODE_UNDERFLOW;
          endcase
        end
        // mostly short drains so final fades end on their own
        if (m == pfr_pkg::MODE_DELETE && $urandom_range(0, 9) < 7)
          d = 16'($urandom_range(0, 24));
        push_word(m, rand_sample(), rand_sample(), d, count == n / 2);
        count++;
        run = late ? $urandom_range(0, 30) : $urandom_range(1, 40);
        while (run != 0 && count < n) begin
          push_word(pfr_pkg::MODE_FRAME, rand_sample(), rand_sample(),
                    16'($urandom_range(0, 65535)), count == n / 2);
          count++;
          run--;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, span below the fade length
    set_config(16'd768, 16'd720);
    idle_pct = 0;
    // pass-through in uninit, sample extremes
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MIN, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, 24'sd0, -24'sd1, 16'hFFFF, 1'b0);
    // unknown modes give a zero word
    push_word(4'd9, S_MAX, S_MAX, 16'hAAAA, 1'b0);
    push_word(4'd15, S_MIN, S_MIN, 16'h5555, 1'b0);
    // init loads 768, above the span, so fade-in gain pins at zero
    push_word(pfr_pkg::MODE_INIT, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MIN, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MIN, S_MAX, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_QUEUED, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MAX, 16'd0, 1'b0);
    // underflow restarts the fade-in
    push_word(pfr_pkg::MODE_UNDERFLOW, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MIN, S_MIN, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, 24'sd1, -24'sd1, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MIN, 16'd0, 1'b0);
    // pause turns the ramp around into a short fade-out
    push_word(pfr_pkg::MODE_PAUSE, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MIN, 16'd0, 1'b0);
    // unpause mid fade-out, then pause again and run the fade to its end
    push_word(pfr_pkg::MODE_UNPAUSE, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_PAUSE, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MAX, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MIN, S_MIN, 16'd0, 1'b0);
    // paused stream is silent
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MIN, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_UNPAUSE, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(4'd12, S_MAX, S_MIN, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_QUEUED, 24'sd0, 24'sd0, 16'd0, 1'b0);
    wait_idle();

    // random phases over several settings, extremes among them
    idle_pct = 15;
    set_config(16'd768, 16'd720);
    push_traffic(150, 1'b0);
    wait_idle();

    // zero fade length: init leaves a zero total for later fade-outs
    set_config(16'd0, 16'd1);
    push_word(pfr_pkg::MODE_INIT, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_traffic(150, 1'b0);
    wait_idle();

    // widest fade; a pause soon after makes a fade-out over a stale total
    idle_pct = 30;
    set_config(16'd65535, 16'd65535);
    push_word(pfr_pkg::MODE_UNPAUSE, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MAX, S_MIN, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_FRAME, S_MIN, S_MAX, 16'd0, 1'b0);
    push_word(pfr_pkg::MODE_PAUSE, 24'sd0, 24'sd0, 16'd0, 1'b0);
    push_traffic(120, 1'b0);
    wait_idle();

    idle_pct = 10;
    set_config(16'd16, 16'd8);
    push_traffic(200, 1'b0);
    wait_idle();

    idle_pct = 25;
    set_config(16'd5, 16'd40);
    push_traffic(150, 1'b0);
    wait_idle();

    idle_pct = 0;
    set_config(16'd1, 16'd65535);
    push_traffic(120, 1'b0);
    wait_idle();

    idle_pct = 20;
    set_config(16'($urandom_range(2, 60)), 16'($urandom_range(1, 60)));
    push_traffic(200, 1'b0);
    wait_idle();

    // leave the normal region: eos, delete and error cycles
    idle_pct = 15;
    set_config(16'd24, 16'd12);
    push_traffic(230, 1'b1);
    while (pending_words.size() != 0) @(posedge clk);
    // closing stretch with both sides always ready
    calm = 1'b1;
    push_traffic(100, 1'b1);
    wait_idle();

    leftovers = expected_words.size();
    if (leftovers != 0) $display("%0d expected output words never arrived", leftovers);

    $display("covered %0d words under %0d register settings, %0d of them on a gain ramp",
             words_sent, settings_used, ramp_frames);
    $display("stream states reached, one bit per state code: %b", states_seen);
    if (mismatches == 0 && leftovers == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog on total run length
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
hdl/pfr_pkg.sv
hdl/pfr_div.sv
hdl/pfr_mul.sv
hdl/pause_fade_ramp_controller.sv
tb/tb_top.sv
